/* hdl/dts_pkg.sv */
// ============================================================================
// dts_pkg - shared types and constants for the DMA transfer splitter
// Sequencer state encoding, compare flags and chunk sizing helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dts_pkg;

    // chunk length width on the result side
    localparam int CHUNK_W = 32;

    // doubleword and burst geometry, in bytes
    localparam int DWORD_BYTES  = 8;
    localparam int HALF_BURST   = 16;
    localparam int BURST_LOG2   = 5;
    localparam int OFFSET_W     = 3;

    localparam logic [CHUNK_W-1:0] CHUNK_MAX = '1;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_AFLUSH = 8'b0000_0010,
        ST_APIECE = 8'b0000_0100,
        ST_CLASS  = 8'b0000_1000,
        ST_WHOLE  = 8'b0001_0000,
        ST_SPLIT  = 8'b0010_0000,
        ST_TAIL   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    // flags from the shared subtractor
    typedef struct packed {
        logic borrow;
        logic zero;
    } cmp_t;

    // half the top power of two of a sub-burst residue (valid for 9..31)
    function automatic logic [BURST_LOG2-1:0] half_top_pow(
        input logic [BURST_LOG2-1:0] v
    );
        logic [BURST_LOG2-1:0] p;
        begin
            if (v[4])
            begin
                p = 5'd8;
            end
            else if (v[3])
            begin
                p = 5'd4;
            end
            else
            begin
                p = 5'd0;
            end
            return p;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/dts_sub_unit.sv */
// ============================================================================
// dts_sub_unit - shared length subtractor
// Remaining length minus a piece size, with borrow and zero flags.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dts_sub_unit #(
    parameter int W = 24
) (
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic [W-1:0]      diff,
    output dts_pkg::cmp_t     cmp
);

    logic [W:0] wide;

    assign wide       = {1'b0, a} - {1'b0, b};
    assign diff       = wide[W-1:0];
    assign cmp.borrow = wide[W];
    assign cmp.zero   = (wide[W-1:0] == '0);

endmodule

`default_nettype wire

/* hdl/dma_transfer_splitter.sv */
// ============================================================================
// dma_transfer_splitter - scatter-gather segment to device chunk splitter
// Takes one segment length per beat and emits the device-side chunks it
// causes. A segment is accepted in idle, then the sequencer takes one
// step per phase (open-chunk flush, misalignment piece, classify, 32-byte
// multiple, one step per power-of-two piece plus one for the remainder,
// tail, final release), with the shared subtractor and at most one chunk
// produced per step; a stalled result channel adds cycles. s_tready is high
// only while the sequencer is idle.
// Chunks are held one deep so the last chunk of a segment can be marked
// (m_tlast); the last chunk of a segment with s_tlast set carries
// transfer_end. Clean segments (8, 16 or a multiple of 32 bytes on an aligned
// address) merge into an open chunk that saturates at all ones and reports
// overflow when it leaves. start_offset is written on the cfg channel while
// idle (cfg_ready follows s_tready) and also reloads the running doubleword
// offset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dma_transfer_splitter #(
    parameter int SEGMENT_LENGTH_BITS = 24,
    localparam int S_TDATA_W = ((SEGMENT_LENGTH_BITS + 7) / 8) * 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // configuration: start_offset
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_data,

    // segment beats
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [0+:SEGMENT_LENGTH_BITS] segment_length
    input  wire logic                 s_tlast,   // is_last

    // chunk beats
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // [31:0] chunk_length
    output logic                      m_tlast,   // run_last
    output logic [1:0]                m_tuser    // [0] transfer_end, [1] overflow
);

    localparam int LW = SEGMENT_LENGTH_BITS;
    localparam int CW = dts_pkg::CHUNK_W;
    localparam int OW = dts_pkg::OFFSET_W;
    localparam int BL = dts_pkg::BURST_LOG2;

    // ---------------------------------------------------------------- state
    dts_pkg::state_t state_reg, state_next;

    logic [OW-1:0] start_reg, start_next;
    logic [OW-1:0] align_reg, align_next;
    logic [CW-1:0] open_reg, open_next;
    logic          sat_reg, sat_next;

    // per-segment working registers
    logic [LW-1:0] len_reg, len_next;
    logic          last_reg, last_next;
    logic [OW-1:0] seg_lo_reg, seg_lo_next;

    // one-deep hold so the final chunk of a segment can be tagged
    logic          hold_valid_reg, hold_valid_next;
    logic [CW-1:0] hold_len_reg, hold_len_next;
    logic          hold_ovf_reg, hold_ovf_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_len_reg, out_len_next;
    logic          out_last_reg, out_last_next;
    logic          out_end_reg, out_end_next;
    logic          out_ovf_reg, out_ovf_next;

    // ------------------------------------------------------- shared unit
    logic [OW:0]   piece;       // bytes up to the next doubleword boundary
    logic [BL-1:0] split_p;     // next power-of-two piece of the residue
    logic [LW-1:0] sub_b;
    logic [LW-1:0] sub_diff;
    dts_pkg::cmp_t sub_cmp;

    assign piece   = (OW+1)'(dts_pkg::DWORD_BYTES) - {1'b0, align_reg};
    assign split_p = dts_pkg::half_top_pow(len_reg[BL-1:0]);

    dts_sub_unit #(
        .W (LW)
    ) u_sub (
        .a    (len_reg),
        .b    (sub_b),
        .diff (sub_diff),
        .cmp  (sub_cmp)
    );

    // --------------------------------------------------------- sequencer
    logic          awkward;     // length that can't merge into a burst
    logic [CW:0]   merge_sum;
    logic [CW-1:0] cand_len;    // chunk produced by this step, zero = none
    logic          cand_ovf;
    logic          can_move;    // result register free this cycle
    logic          advance;

    assign awkward = (len_reg[BL-1:0] != '0)
                  && (len_reg != LW'(dts_pkg::HALF_BURST))
                  && (len_reg != LW'(dts_pkg::DWORD_BYTES));

    assign merge_sum = {1'b0, open_reg} + (CW+1)'(len_reg);
    assign can_move  = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next  = state_reg;
        start_next  = start_reg;
        align_next  = align_reg;
        open_next   = open_reg;
        sat_next    = sat_reg;
        len_next    = len_reg;
        last_next   = last_reg;
        seg_lo_next = seg_lo_reg;
        sub_b       = LW'(piece);
        cand_len    = '0;
        cand_ovf    = 1'b0;

        case (state_reg)
            dts_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    len_next    = s_tdata[LW-1:0];
                    last_next   = s_tlast;
                    seg_lo_next = s_tdata[OW-1:0];
                    state_next  = dts_pkg::ST_AFLUSH;
                end
            end
            dts_pkg::ST_AFLUSH:
            begin
                // misaligned start closes whatever is open
                if (align_reg != '0)
                begin
                    cand_len   = open_reg;
                    cand_ovf   = sat_reg;
                    open_next  = '0;
                    sat_next   = 1'b0;
                    state_next = dts_pkg::ST_APIECE;
                end
                else
                begin
                    state_next = dts_pkg::ST_CLASS;
                end
            end
            dts_pkg::ST_APIECE:
            begin
                sub_b = LW'(piece);
                if (!sub_cmp.borrow && !sub_cmp.zero)
                begin
                    cand_len = CW'(piece);
                    len_next = sub_diff;
                end
                else
                begin
                    // whole segment fits before the boundary
                    if (last_reg)
                    begin
                        open_next = CW'(len_reg);
                        sat_next  = 1'b0;
                    end
                    else
                    begin
                        cand_len = CW'(len_reg);
                    end
                    len_next = '0;
                end
                state_next = dts_pkg::ST_CLASS;
            end
            dts_pkg::ST_CLASS:
            begin
                if (awkward)
                begin
                    cand_len   = open_reg;
                    cand_ovf   = sat_reg;
                    open_next  = '0;
                    sat_next   = 1'b0;
                    state_next = dts_pkg::ST_WHOLE;
                end
                else
                begin
                    if (merge_sum[CW])
                    begin
                        open_next = dts_pkg::CHUNK_MAX;
                        sat_next  = 1'b1;
                    end
                    else
                    begin
                        open_next = merge_sum[CW-1:0];
                    end
                    state_next = dts_pkg::ST_TAIL;
                end
            end
            dts_pkg::ST_WHOLE:
            begin
                cand_len   = CW'({len_reg[LW-1:BL], {BL{1'b0}}});
                len_next   = LW'(len_reg[BL-1:0]);
                state_next = dts_pkg::ST_SPLIT;
            end
            dts_pkg::ST_SPLIT:
            begin
                sub_b = LW'(split_p);
                if (len_reg > LW'(dts_pkg::DWORD_BYTES))
                begin
                    cand_len = CW'(split_p);
                    len_next = sub_diff;
                end
                else
                begin
                    if (len_reg != '0)
                    begin
                        if (last_reg)
                        begin
                            open_next = CW'(len_reg);
                            sat_next  = 1'b0;
                        end
                        else
                        begin
                            cand_len = CW'(len_reg);
                        end
                    end
                    state_next = dts_pkg::ST_TAIL;
                end
            end
            dts_pkg::ST_TAIL:
            begin
                align_next = align_reg + seg_lo_reg;
                if (last_reg)
                begin
                    cand_len   = open_reg;
                    cand_ovf   = sat_reg;
                    open_next  = '0;
                    sat_next   = 1'b0;
                    align_next = start_reg;
                end
                state_next = dts_pkg::ST_DONE;
            end
            dts_pkg::ST_DONE:
            begin
                state_next = dts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dts_pkg::ST_IDLE;
            end
        endcase

        // a step that would push the hold into a full result register waits
        if (state_reg == dts_pkg::ST_DONE)
        begin
            advance = !hold_valid_reg || can_move;
        end
        else
        begin
            advance = !((cand_len != '0) && hold_valid_reg && !can_move);
        end

        if (!advance)
        begin
            state_next  = state_reg;
            align_next  = align_reg;
            open_next   = open_reg;
            sat_next    = sat_reg;
            len_next    = len_reg;
            last_next   = last_reg;
            seg_lo_next = seg_lo_reg;
        end

        // config writes land while idle
        if (cfg_valid && cfg_ready)
        begin
            start_next = cfg_data;
            align_next = cfg_data;
        end
    end

    // ------------------------------------------------- hold and result
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_len_next   = hold_len_reg;
        hold_ovf_next   = hold_ovf_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        out_ovf_next    = out_ovf_reg;

        if (advance)
        begin
            if (state_reg == dts_pkg::ST_DONE)
            begin
                // release the last chunk of the segment
                if (hold_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_len_next    = hold_len_reg;
                    out_ovf_next    = hold_ovf_reg;
                    out_last_next   = 1'b1;
                    out_end_next    = last_reg;
                    hold_valid_next = 1'b0;
                end
            end
            else if (cand_len != '0)
            begin
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = hold_len_reg;
                    out_ovf_next   = hold_ovf_reg;
                    out_last_next  = 1'b0;
                    out_end_next   = 1'b0;
                end
                hold_valid_next = 1'b1;
                hold_len_next   = cand_len;
                hold_ovf_next   = cand_ovf;
            end
        end
    end

    // ------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dts_pkg::ST_IDLE;
            start_reg      <= '0;
            align_reg      <= '0;
            open_reg       <= '0;
            sat_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_reg      <= start_next;
            align_reg      <= align_next;
            open_reg       <= open_next;
            sat_reg        <= sat_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        last_reg     <= last_next;
        seg_lo_reg   <= seg_lo_next;
        hold_len_reg <= hold_len_next;
        hold_ovf_reg <= hold_ovf_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // ----------------------------------------------------------- ports
    assign cfg_ready = (state_reg == dts_pkg::ST_IDLE);
    assign s_tready  = (state_reg == dts_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_len_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = {out_ovf_reg, out_end_reg};

    // ------------------------------------------------------ assertions
    // nothing may sit in the hold between segments
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !hold_valid_reg)
        else $error("chunk left in hold while idle");

    // transfer end only on the closing chunk of a segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("transfer_end without run_last");

    // zero-length pieces are never emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata != '0))
        else $error("zero-length chunk emitted");

endmodule

`default_nettype wire

/* test/dma_transfer_splitter_tb.sv */
// ============================================================================
// dma_transfer_splitter_tb - self-checking bench for the DMA transfer splitter
// Streams scatter-gather segment lengths into the block and compares every
// chunk beat with a cycle-free model of the splitting rules. Directed tests
// cover clean and awkward lengths, misaligned starts, an offset write inside
// a transfer and merge saturation. A random phase follows with whole
// transfers, offset changes and random stalls on both streams.
// ============================================================================
`timescale 1ns / 1ps

module dma_transfer_splitter_tb;

    localparam int SEG_W         = 24;
    localparam int MAX_PER_SEG   = 8;    // chunk cap per segment
    localparam int SETTLE_CYCLES = 40;   // margin over the worst-case segment
    localparam int DRAIN_CAP     = 20000;
    localparam int RANDOM_SEGS   = 40;

    // one predicted chunk beat
    typedef struct packed {
        logic [dts_pkg::CHUNK_W-1:0] len;
        logic                        run_last;
        logic                        xfer_end;
        logic                        ovf;
    } chunk_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [SEG_W-1:0]  s_tdata;     // [23:0] segment_length
    logic              s_tlast;     // is_last
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;     // [31:0] chunk_length
    logic              m_tlast;     // run_last
    logic [1:0]        m_tuser;     // [0] transfer_end, [1] overflow

    // model state
    logic [2:0]                  cfg_offset;
    logic [2:0]                  run_offset;
    logic [dts_pkg::CHUNK_W-1:0] open_len;
    logic                        open_sat;
    chunk_t                      seg_chunks[$];
    chunk_t                      pending_chunks[$];

    // pacing
    logic src_quiet  = 1'b0;
    logic sink_quiet = 1'b0;

    int errors       = 0;
    int segs_sent    = 0;
    int chunks_seen  = 0;
    int sat_seen     = 0;
    int offset_wr    = 0;

    dma_transfer_splitter #(
        .SEGMENT_LENGTH_BITS(SEG_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Splitting model
    // ------------------------------------------------------------------------

    // zero-byte pieces never leave; at most eight chunks per segment
    function automatic void emit_piece(logic [dts_pkg::CHUNK_W-1:0] len, logic ovf);
        chunk_t c;
        if (len != '0 && seg_chunks.size() < MAX_PER_SEG)
        begin
            c.len      = len;
            c.run_last = 1'b0;
            c.xfer_end = 1'b0;
            c.ovf      = ovf;
            seg_chunks.push_back(c);
        end
    endfunction

    function automatic void close_open();
        emit_piece(open_len, open_sat);
        open_len = '0;
        open_sat = 1'b0;
    endfunction

    // works out the chunks one accepted segment causes and queues them
    function automatic void split_segment(logic [SEG_W-1:0] seg, logic last);
        logic [dts_pkg::CHUNK_W-1:0] rest;
        logic [dts_pkg::CHUNK_W-1:0] piece;
        logic [dts_pkg::CHUNK_W-1:0] whole;
        logic [dts_pkg::CHUNK_W-1:0] scan;
        logic [dts_pkg::CHUNK_W:0]   total;
        chunk_t                      c;
        int                          k;
        seg_chunks.delete();
        rest = {{(dts_pkg::CHUNK_W-SEG_W){1'b0}}, seg};

        // misaligned device address: fill up to the next doubleword
        if (run_offset != 3'd0)
        begin
            piece = 32'd8 - {29'd0, run_offset};
            close_open();
            if (rest > piece)
            begin
                emit_piece(piece, 1'b0);
                rest = rest - piece;
            end
            else
            begin
                open_len = rest;
                open_sat = 1'b0;
                rest     = '0;
                if (!last)
                begin
                    close_open();
                end
            end
        end

        if (rest[4:0] != 5'd0 && rest != 32'd16 && rest != 32'd8)
        begin
            // awkward length: burst multiple, halving pieces, tail
            whole = {rest[dts_pkg::CHUNK_W-1:5], 5'd0};
            close_open();
            emit_piece(whole, 1'b0);
            rest = rest - whole;
            while (rest > 32'd8)
            begin
                k    = 0;
                scan = rest;
                while (scan > 32'd1)
                begin
                    scan = scan >> 1;
                    k++;
                end
                piece = 32'd1 << (k - 1);
                emit_piece(piece, 1'b0);
                rest = rest - piece;
            end
            if (rest != '0)
            begin
                if (last)
                begin
                    open_len = rest;
                    open_sat = 1'b0;
                end
                else
                begin
                    emit_piece(rest, 1'b0);
                end
            end
        end
        else
        begin
            // clean length merges, saturating at all ones
            total = {1'b0, open_len} + {1'b0, rest};
            if (total[dts_pkg::CHUNK_W])
            begin
                open_len = dts_pkg::CHUNK_MAX;
                open_sat = 1'b1;
            end
            else
            begin
                open_len = total[dts_pkg::CHUNK_W-1:0];
            end
        end

        run_offset = run_offset + seg[2:0];

        if (last)
        begin
            close_open();
            run_offset = cfg_offset;
        end

        if (seg_chunks.size() > 0)
        begin
            c          = seg_chunks.pop_back();
            c.run_last = 1'b1;
            c.xfer_end = last;
            seg_chunks.push_back(c);
        end
        foreach (seg_chunks[i])
        begin
            pending_chunks.push_back(seg_chunks[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int pick_gap(logic quiet);
        return quiet ? 0 : int'($urandom_range(0, 19));
    endfunction

    // one segment beat; valid stays up afterwards so back-to-back beats
    // never see a low-then-high in the same step
    task automatic send_segment(input logic [SEG_W-1:0] len, input logic last);
        int gap;
        gap = pick_gap(src_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        split_segment(len, last);
        segs_sent++;
    endtask

    // stop sending, wait for every queued chunk, then let a zero-output
    // segment finish inside the block
    task automatic settle_idle();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (pending_chunks.size() != 0 && n < DRAIN_CAP)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_offset(input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid  <= 1'b0;
        cfg_offset  = value;
        run_offset  = value;
        offset_wr++;
    endtask

    function automatic logic [SEG_W-1:0] random_length();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            case ($urandom_range(0, 2))
                0: return 24'd8;
                1: return 24'd16;
                default: return 24'(32 * $urandom_range(1, 64));
            endcase
        end
        else if (kind <= 6)
        begin
            return 24'($urandom_range(1, 63));
        end
        else if (kind <= 8)
        begin
            return 24'($urandom_range(1, 4095));
        end
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // aligned start: merges, awkward splits, extremes of the length field
    task automatic test_clean_and_awkward_lengths();
        send_segment(24'd8, 1'b0);
        send_segment(24'd16, 1'b0);
        send_segment(24'd32, 1'b0);
        send_segment(24'hFF_FFFF, 1'b1);
        send_segment(24'd1, 1'b1);
        send_segment(24'd9, 1'b0);
        send_segment(24'd17, 1'b0);
        send_segment(24'd33, 1'b1);
        send_segment(24'hFF_FFE0, 1'b1);
        send_segment(24'd31, 1'b0);
        send_segment(24'd16, 1'b1);
    endtask

    // misaligned start offsets, short segments that fit in the fill piece
    task automatic test_misaligned_start();
        settle_idle();
        write_start_offset(3'd7);
        send_segment(24'd1, 1'b0);
        send_segment(24'd64, 1'b0);
        send_segment(24'd5, 1'b1);
        settle_idle();
        write_start_offset(3'd3);
        send_segment(24'd2, 1'b1);
        send_segment(24'd200, 1'b1);
        settle_idle();
        write_start_offset(3'd1);
        send_segment(24'd7, 1'b0);
        send_segment(24'd100, 1'b1);
    endtask

    // offset write keeps the open chunk and reloads the running offset
    task automatic test_offset_write_mid_transfer();
        settle_idle();
        write_start_offset(3'd0);
        send_segment(24'd32, 1'b0);
        send_segment(24'd8, 1'b0);
        settle_idle();
        write_start_offset(3'd4);
        send_segment(24'd100, 1'b1);
    endtask

    // enough max clean bursts to push the open chunk past 32 bits; the
    // closing segment carries the saturated chunk out with overflow set
    task automatic test_merge_saturation();
        settle_idle();
        write_start_offset(3'd0);
        src_quiet = 1'b1;
        repeat (256) send_segment(24'hFF_FFE0, 1'b0);
        send_segment(24'hFF_FFE0, 1'b1);
        src_quiet = 1'b0;
    endtask

    // whole transfers with random content, offset changes between them and
    // now and then inside one
    task automatic test_random_transfers();
        int sent;
        int nseg;
        sent = 0;
        while (sent < RANDOM_SEGS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                settle_idle();
                write_start_offset(3'($urandom_range(0, 7)));
            end
            src_quiet = ($urandom_range(0, 4) == 0);
            nseg = $urandom_range(1, 8);
            for (int i = 0; i < nseg; i++)
            begin
                if (i > 0 && $urandom_range(0, 29) == 0)
                begin
                    settle_idle();
                    write_start_offset(3'($urandom_range(0, 7)));
                end
                send_segment(random_length(), i == nseg - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                settle_idle();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the chunk checker
    // ------------------------------------------------------------------------

    initial
    begin
        int stall;
        forever
        begin
            stall = pick_gap(sink_quiet);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            if ($urandom_range(0, 24) == 0)
            begin
                sink_quiet = ~sink_quiet;
            end
        end
    end

    always @(posedge clk)
    begin : chunk_check
        chunk_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chunks.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected chunk beat len=%0d last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                want = pending_chunks.pop_front();
                chunks_seen++;
                if (m_tuser[1])
                begin
                    sat_seen++;
                end
                if (m_tdata !== want.len)
                begin
                    errors++;
                    $display("%0t: chunk_length expected %0d actual %0d",
                             $time, want.len, m_tdata);
                end
                if (m_tlast !== want.run_last)
                begin
                    errors++;
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, m_tlast);
                end
                if (m_tuser[0] !== want.xfer_end)
                begin
                    errors++;
                    $display("%0t: transfer_end expected %b actual %b",
                             $time, want.xfer_end, m_tuser[0]);
                end
                if (m_tuser[1] !== want.ovf)
                begin
                    errors++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.ovf, m_tuser[1]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 3'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_offset = 3'd0;
        run_offset = 3'd0;
        open_len   = '0;
        open_sat   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_clean_and_awkward_lengths();
        test_misaligned_start();
        test_offset_write_mid_transfer();
        test_merge_saturation();
        test_random_transfers();
        settle_idle();

        if (pending_chunks.size() != 0)
        begin
            errors++;
            $display("%0t: %0d chunk(s) never arrived, next expected len=%0d",
                     $time, pending_chunks.size(), pending_chunks[0].len);
        end

        $display("covered %0d segments, %0d chunk beats checked, %0d saturated,",
                 segs_sent, chunks_seen, sat_seen);
        $display("%0d start offset writes, random stalls on both streams", offset_wr);
        if (errors == 0)
        begin
            $display("dma_transfer_splitter_tb: done, clean");
        end
        else
        begin
            $display("dma_transfer_splitter_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d chunk(s) still expected", $time, pending_chunks.size());
        $display("dma_transfer_splitter_tb: done, errors");
        $finish;
    end

endmodule
